// ===== rtl/core/abfc_pkg.sv =====
// Shared types, widths and register codes for the box versus frustum culling block.
package abfc_pkg;

	// Number of planes tested, in register order (4 to 6).
	localparam int PLANE_COUNT = 6;
	// Number of plane registers present on the configuration port.
	localparam int NUM_PLANES = 6;

	localparam int COORD_W = 32;              // Q28.4 world coordinate
	localparam int REL_W = COORD_W + 1;       // corner minus camera, exact
	localparam int COEF_W = 16;               // a, b, c in Q1.14, d in Q12.4
	localparam int PROD_W = COEF_W + REL_W;   // one normal term
	localparam int SUM_W = PROD_W + 3;        // three terms plus scaled d
	localparam int D_SHIFT = 14;              // aligns d to the product fraction
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam int IN_W = 6 * COORD_W;
	localparam int OUT_W = 8;

	// Register indexes, byte address is 8 times the index.
	typedef enum logic [2:0] {
		REG_PLANE_LEFT   = 3'd0,
		REG_PLANE_RIGHT  = 3'd1,
		REG_PLANE_BOTTOM = 3'd2,
		REG_PLANE_TOP    = 3'd3,
		REG_PLANE_NEAR   = 3'd4,
		REG_PLANE_FAR    = 3'd5,
		REG_CAMERA_XY    = 3'd6,
		REG_CAMERA_Z     = 3'd7
	} reg_idx_t;

	// Configuration state handed from the register file to the datapath.
	typedef struct packed {
		logic [NUM_PLANES-1:0][DATA_W-1:0] plane;
		logic [COORD_W-1:0]                cam_x;
		logic [COORD_W-1:0]                cam_y;
		logic [COORD_W-1:0]                cam_z;
	} cfg_t;

	// Box relative to the camera plus the running visibility flag.
	typedef struct packed {
		logic [2:0][REL_W-1:0] lo;
		logic [2:0][REL_W-1:0] hi;
		logic                  vis;
	} box_t;

	// Stage occupancy of one cell.
	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} cell_stat_t;

endpackage

// ===== rtl/core/abfc_cfg.sv =====
// Register file with the APB-style configuration port.
module abfc_cfg import abfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [NUM_PLANES-1:0][DATA_W-1:0] plane_q;
	logic [DATA_W-1:0]                 cam_xy_q;
	logic [COORD_W-1:0]                cam_z_q;
	logic                              wr_en;
	reg_idx_t                          idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

	// Register writes, taken in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q  <= '0;
			cam_xy_q <= '0;
			cam_z_q  <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PLANE_LEFT:   plane_q[0] <= pwdata;
				REG_PLANE_RIGHT:  plane_q[1] <= pwdata;
				REG_PLANE_BOTTOM: plane_q[2] <= pwdata;
				REG_PLANE_TOP:    plane_q[3] <= pwdata;
				REG_PLANE_NEAR:   plane_q[4] <= pwdata;
				REG_PLANE_FAR:    plane_q[5] <= pwdata;
				REG_CAMERA_XY:    cam_xy_q   <= pwdata;
				REG_CAMERA_Z:     cam_z_q    <= pwdata[COORD_W-1:0];
				default:          ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_PLANE_LEFT:   prdata = plane_q[0];
			REG_PLANE_RIGHT:  prdata = plane_q[1];
			REG_PLANE_BOTTOM: prdata = plane_q[2];
			REG_PLANE_TOP:    prdata = plane_q[3];
			REG_PLANE_NEAR:   prdata = plane_q[4];
			REG_PLANE_FAR:    prdata = plane_q[5];
			REG_CAMERA_XY:    prdata = cam_xy_q;
			REG_CAMERA_Z:     prdata = DATA_W'(cam_z_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.plane = plane_q;
	assign cfg.cam_x = cam_xy_q[COORD_W-1:0];
	assign cfg.cam_y = cam_xy_q[DATA_W-1:COORD_W];
	assign cfg.cam_z = cam_z_q;

endmodule

// ===== rtl/core/abfc_cell.sv =====
// One plane cell: picks the far corner, forms the plane distance and updates the flag.
module abfc_cell import abfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DATA_W-1:0] plane,
	input  logic              in_valid,
	output logic              in_ready,
	input  box_t              in_box,
	output logic              out_valid,
	input  logic              out_ready,
	output box_t              out_box,
	output cell_stat_t        stat
);

	logic                            v_s1;
	logic                            v_s2;
	box_t                            box_s1;
	box_t                            box_s2;
	logic signed [PROD_W-1:0]        prod_s1 [3];
	logic signed [COEF_W-1:0]        d_s1;
	logic signed [COEF_W-1:0]        n_c [3];
	logic signed [REL_W-1:0]         corner_c [3];
	logic signed [PROD_W-1:0]        prod_c [3];
	logic signed [SUM_W-1:0]         sum_c;
	logic                            ready_s1;
	logic                            load_s2;

	// Handshake between the two stages; a bubble is filled while the tail waits.
	assign load_s2   = v_s1 && (!v_s2 || out_ready);
	assign ready_s1  = !v_s1 || load_s2;
	assign in_ready  = ready_s1;
	assign out_valid = v_s2;
	assign out_box   = box_s2;
	assign stat.v_s1 = v_s1;
	assign stat.v_s2 = v_s2;

	// Corner selection per axis and one multiplier per axis.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_c[k]      = $signed(plane[COEF_W*k +: COEF_W]);
			corner_c[k] = n_c[k][COEF_W-1] ? $signed(in_box.lo[k]) : $signed(in_box.hi[k]);
			prod_c[k]   = n_c[k] * corner_c[k];
		end
	end

	// Distance: the three terms plus d aligned to the product fraction.
	assign sum_c = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2])
		+ (SUM_W'(d_s1) <<< D_SHIFT);

	// Stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (!v_s2 || out_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			box_s1 <= in_box;
			d_s1   <= $signed(plane[DATA_W-1 -: COEF_W]);
			for (int k = 0; k < 3; k++) begin
				prod_s1[k] <= prod_c[k];
			end
		end
		if (load_s2) begin
			box_s2 <= {box_s1.lo, box_s1.hi, box_s1.vis && !sum_c[SUM_W-1]};
		end
	end

	// A box once culled stays culled.
	a_vis_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> !(box_s2.vis && !$past(box_s1.vis)))
		else $error("cell set visible on a culled box");

	// Back-pressure upstream only when both stages hold a word.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2))
		else $error("cell stalled with an empty stage");

endmodule

// ===== rtl/core/aabb_frustum_cull_top.sv =====
// Top level of the box versus frustum culling block: entry stage and the chain of plane cells.
//
// One box enters per cycle while the input is ready: an entry stage subtracts the camera,
// then each plane cell spends one stage on the three normal products and one on the sum
// and sign test. Every stage holds one word and moves on whenever the stage after it is
// empty or draining, so gaps close up under output back-pressure and the input stays ready
// until every stage is full. The user must write configuration through the APB port only
// while no box is in flight; the block itself does not enforce this.
module aabb_frustum_cull_top import abfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, 32 bits each
	input  logic [IN_W-1:0]   s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// visible in bit 0, zeros above
	output logic [OUT_W-1:0]  m_axis_tdata
);

	localparam int STAGES = 1 + 2 * PLANE_COUNT;
	localparam int CNT_W = $clog2(STAGES + 1);

	cfg_t                      cfg;
	logic                      v_s0;
	box_t                      box_s0;
	logic                      in_acc;
	logic                      out_acc;
	logic [PLANE_COUNT:0]      chain_valid;
	logic [PLANE_COUNT:0]      chain_ready;
	box_t                      chain_box [PLANE_COUNT+1];
	cell_stat_t                stat [PLANE_COUNT];
	logic [STAGES-1:0]         occ;
	logic [CNT_W-1:0]          inflight_q;
	logic [2:0][COORD_W-1:0]   cam;

	abfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign cam[0]  = cfg.cam_x;
	assign cam[1]  = cfg.cam_y;
	assign cam[2]  = cfg.cam_z;

	assign s_axis_tready = !v_s0 || chain_ready[0];
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	// Entry stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s0 <= s_axis_tvalid;
		end
	end

	// Corners relative to the camera, exact at one extra bit.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			box_s0.vis <= 1'b1;
			for (int k = 0; k < 3; k++) begin
				box_s0.lo[k] <= $signed({s_axis_tdata[COORD_W*k + COORD_W-1],
					s_axis_tdata[COORD_W*k +: COORD_W]})
					- $signed({cam[k][COORD_W-1], cam[k]});
				box_s0.hi[k] <= $signed({s_axis_tdata[COORD_W*(k+3) + COORD_W-1],
					s_axis_tdata[COORD_W*(k+3) +: COORD_W]})
					- $signed({cam[k][COORD_W-1], cam[k]});
			end
		end
	end

	assign chain_valid[0] = v_s0;
	assign chain_box[0]   = box_s0;
	assign occ[0]         = v_s0;

	// One cell per tested plane.
	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
		abfc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.plane     (cfg.plane[i]),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_box    (chain_box[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_box   (chain_box[i+1]),
			.stat      (stat[i])
		);
		assign occ[2*i+1] = stat[i].v_s1;
		assign occ[2*i+2] = stat[i].v_s2;
	end

	assign chain_ready[PLANE_COUNT] = m_axis_tready;
	assign m_axis_tvalid = chain_valid[PLANE_COUNT];
	assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, chain_box[PLANE_COUNT].vis};

	// Words in flight, kept to cross-check the stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// No word is lost or duplicated along the chain.
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CNT_W'($countones(occ)))
		else $error("stage occupancy disagrees with words in flight");

	// The input stalls only when the entry stage holds a word.
	a_entry_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s0)
		else $error("input stalled with an empty entry stage");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the box versus frustum culling block.
`timescale 1ns / 100ps

module tb;
	import abfc_pkg::*;

	localparam int RAND_PHASES = 14;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int NUM_REGS = NUM_PLANES + 2;
	localparam int DRAIN_CYCLES = 1 + 2 * PLANE_COUNT + 8;
	localparam logic [31:0] NEG = 32'h8000_0000;
	localparam logic [31:0] POS = 32'h7FFF_FFFF;
	localparam logic [31:0] ONES = 32'hFFFF_FFFF;

	// Directed plane settings used by the opening table.
	typedef enum logic [1:0] {
		CFG_RESET,
		CFG_ONE_NEG_D,
		CFG_SLAB_X,
		CFG_EXTREME
	} dir_cfg_e;

	// Flavors of random plane settings.
	typedef enum logic [1:0] {
		STYLE_CORNER,
		STYLE_FRUSTUM,
		STYLE_SCATTER
	} bank_style_e;

	// One box, in the order the fields appear on the bus.
	typedef struct packed {
		logic [31:0] mnx;
		logic [31:0] mny;
		logic [31:0] mnz;
		logic [31:0] mxx;
		logic [31:0] mxy;
		logic [31:0] mxz;
	} corners_t;

	// A directed row; the visibility is typed in only where it is obvious.
	typedef struct packed {
		dir_cfg_e cfg;
		logic     typed;
		logic     vis;
		corners_t box;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, 32 bits each
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// visible in bit 0, zeros above
	logic [OUT_W-1:0]  m_axis_tdata;

	// Shadow of the register file and the queue of predicted visibility words.
	logic [DATA_W-1:0] plane_mirror [NUM_PLANES];
	logic [31:0]       cam_mirror [3];
	logic [DATA_W-1:0] reg_bank [NUM_REGS];
	logic              vis_expected [$];
	int                mismatch_count = 0;
	bit                source_calm = 1'b0;
	bit                sink_calm = 1'b0;
	int                stall_left = 0;
	logic              want_vis;

	aabb_frustum_cull_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Guard against a hung pipeline.
	initial begin
		#25_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Visibility of one box under the mirrored planes and camera: p-vertex test per plane.
	function automatic logic cull_visible(corners_t c);
		logic [31:0] mn [3];
		logic [31:0] mx [3];
		longint      lo [3];
		longint      hi [3];
		longint      dist_sum;
		longint      n;
		mn = '{c.mnx, c.mny, c.mnz};
		mx = '{c.mxx, c.mxy, c.mxz};
		for (int k = 0; k < 3; k++) begin
			lo[k] = longint'($signed(mn[k])) - longint'($signed(cam_mirror[k]));
			hi[k] = longint'($signed(mx[k])) - longint'($signed(cam_mirror[k]));
		end
		for (int p = 0; p < PLANE_COUNT && p < NUM_PLANES; p++) begin
			dist_sum = longint'($signed(plane_mirror[p][63:48])) <<< D_SHIFT;
			for (int k = 0; k < 3; k++) begin
				n = longint'($signed(plane_mirror[p][16*k +: 16]));
				dist_sum += n * ((n < 0) ? lo[k] : hi[k]);
			end
			if (dist_sum < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Idle lengths: mostly short, now and then long.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] extreme_coord();
		case ($urandom_range(0, 3))
			0: return NEG;
			1: return POS;
			2: return ONES;
			default: return 32'h0;
		endcase
	endfunction

	function automatic logic [15:0] corner_coef();
		case ($urandom_range(0, 6))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			4: return 16'h4000;
			5: return 16'hC000;
			default: return 16'h0000;
		endcase
	endfunction

	// Random box: mostly near the camera at mixed scales, some scattered, some extreme.
	function automatic corners_t random_corners();
		corners_t    c;
		logic [31:0] mn [3];
		logic [31:0] mx [3];
		logic [31:0] ctr;
		logic [31:0] half;
		int          r;
		int          span;
		r = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++) begin
			if (r < 12) begin
				mn[k] = $urandom;
				mx[k] = $urandom;
			end else if (r < 17) begin
				mn[k] = extreme_coord();
				mx[k] = extreme_coord();
			end else begin
				span = 1 << (4 * $urandom_range(1, 4));
				ctr = cam_mirror[k] + ($urandom_range(0, 2 * span) - span);
				half = $urandom_range(0, span / 4);
				mn[k] = ctr - half;
				mx[k] = ctr + half;
				if (r > 94) begin
					mn[k] = ctr + half;
					mx[k] = ctr - half;
				end
			end
		end
		c = '{mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]};
		return c;
	endfunction

	// Output back-pressure.
	always @(posedge clk) begin
		if (stall_left == 0 && !sink_calm && $urandom_range(0, 99) < 25)
			stall_left = gap_length();
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (vis_expected.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time,
					m_axis_tdata);
				mismatch_count++;
			end else begin
				want_vis = vis_expected.pop_front();
				if (m_axis_tdata !== OUT_W'(want_vis)) begin
					$display("%0t: visible mismatch, expected %h, actual %h", $time,
						OUT_W'(want_vis), m_axis_tdata);
					mismatch_count++;
				end
			end
		end
	end

	// One APB write: setup, access, then idle; mirrors the register.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(idx) * 8);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_CAMERA_XY: begin
				cam_mirror[0] = data[31:0];
				cam_mirror[1] = data[63:32];
			end
			REG_CAMERA_Z: begin
				cam_mirror[2] = data[31:0];
			end
			default: begin
				plane_mirror[int'(idx)] = data;
			end
		endcase
		@(posedge clk);
	endtask

	task automatic load_bank();
		for (int i = REG_PLANE_LEFT; i <= REG_CAMERA_Z; i++)
			write_reg(reg_idx_t'(i), reg_bank[i]);
	endtask

	// Offer one box, wait for the handshake, record the prediction, maybe idle.
	task automatic send_corners(corners_t c, logic typed, logic typed_vis);
		logic vis;
		vis = typed ? typed_vis : cull_visible(c);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c.mxz, c.mxy, c.mxx, c.mnz, c.mny, c.mnx};
		do @(posedge clk); while (!s_axis_tready);
		vis_expected.push_back(vis);
		if (!source_calm && $urandom_range(0, 99) < 25) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap_length()) @(posedge clk);
		end
	endtask

	// Stop offering boxes and wait until every word has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (vis_expected.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic build_directed_bank(dir_cfg_e which);
		for (int i = 0; i < NUM_REGS; i++)
			reg_bank[i] = '0;
		case (which)
			CFG_ONE_NEG_D: begin
				// Only a negative offset: every box falls outside.
				reg_bank[REG_PLANE_LEFT] = 64'hFFFF_0000_0000_0000;
				reg_bank[REG_CAMERA_XY] = {POS, NEG};
				reg_bank[REG_CAMERA_Z] = {ONES, NEG};
			end
			CFG_SLAB_X: begin
				// Two opposite x planes through the origin.
				reg_bank[REG_PLANE_LEFT] = 64'h0000_0000_0000_4000;
				reg_bank[REG_PLANE_RIGHT] = 64'h0000_0000_0000_C000;
			end
			CFG_EXTREME: begin
				reg_bank[REG_PLANE_LEFT] = 64'h7FFF_0000_7FFF_8000;
				reg_bank[REG_PLANE_RIGHT] = 64'h8000_FFFF_8000_7FFF;
				reg_bank[REG_PLANE_BOTTOM] = 64'h7FFF_8000_0000_0000;
				reg_bank[REG_PLANE_TOP] = 64'hFFFF_FFFF_FFFF_FFFF;
				reg_bank[REG_PLANE_NEAR] = 64'h0001_C000_4000_0001;
				reg_bank[REG_PLANE_FAR] = 64'h7FFF_7FFF_7FFF_7FFF;
				reg_bank[REG_CAMERA_XY] = {POS, NEG};
				reg_bank[REG_CAMERA_Z] = {ONES, NEG};
			end
			default: begin
			end
		endcase
	endtask

	task automatic build_random_bank(bank_style_e style);
		logic [15:0] d;
		for (int p = 0; p < NUM_PLANES; p++) begin
			case (style)
				STYLE_CORNER: begin
					reg_bank[p] = {corner_coef(), corner_coef(), corner_coef(), corner_coef()};
				end
				STYLE_FRUSTUM: begin
					// Small offsets so the normal terms decide; some planes left open.
					d = 16'($urandom_range(0, 2303) - 256);
					if ($urandom_range(0, 99) < 35)
						reg_bank[p] = '0;
					else
						reg_bank[p] = {d, 16'($urandom), 16'($urandom), 16'($urandom)};
				end
				default: begin
					reg_bank[p] = {$urandom, $urandom};
				end
			endcase
		end
		if (style == STYLE_CORNER) begin
			reg_bank[REG_CAMERA_XY] = {extreme_coord(), extreme_coord()};
			reg_bank[REG_CAMERA_Z] = {$urandom, extreme_coord()};
		end else begin
			reg_bank[REG_CAMERA_XY] = {$urandom, $urandom};
			reg_bank[REG_CAMERA_Z] = {$urandom, $urandom};
		end
	endtask

	// Main sequence: reset, directed table, random phases, final verdict.
	initial begin
		dir_row_t dir_rows [21];
		dir_cfg_e cur_cfg;
		dir_rows = '{
			'{CFG_RESET, 1'b1, 1'b1, '{0, 0, 0, 0, 0, 0}},
			'{CFG_RESET, 1'b1, 1'b1, '{NEG, NEG, NEG, POS, POS, POS}},
			'{CFG_RESET, 1'b1, 1'b1, '{POS, POS, POS, NEG, NEG, NEG}},
			'{CFG_RESET, 1'b1, 1'b1, '{ONES, ONES, ONES, ONES, ONES, ONES}},
			'{CFG_ONE_NEG_D, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
			'{CFG_ONE_NEG_D, 1'b1, 1'b0, '{NEG, NEG, NEG, POS, POS, POS}},
			'{CFG_ONE_NEG_D, 1'b1, 1'b0, '{POS, POS, POS, NEG, NEG, NEG}},
			'{CFG_SLAB_X, 1'b1, 1'b1, '{0, 0, 0, 0, 0, 0}},
			'{CFG_SLAB_X, 1'b1, 1'b1, '{32'hFFFF_FFFB, POS, NEG, 32'd5, NEG, POS}},
			'{CFG_SLAB_X, 1'b1, 1'b0, '{32'hFFFF_FFFB, 0, 0, ONES, 0, 0}},
			'{CFG_SLAB_X, 1'b1, 1'b0, '{32'd1, 0, 0, 32'd5, 0, 0}},
			'{CFG_SLAB_X, 1'b1, 1'b0, '{32'd5, 0, 0, 32'hFFFF_FFFB, 0, 0}},
			'{CFG_SLAB_X, 1'b1, 1'b1, '{NEG, ONES, 0, POS, 0, ONES}},
			'{CFG_SLAB_X, 1'b1, 1'b0, '{POS, 0, 0, NEG, 0, 0}},
			'{CFG_EXTREME, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
			'{CFG_EXTREME, 1'b0, 1'b0, '{NEG, NEG, NEG, POS, POS, POS}},
			'{CFG_EXTREME, 1'b0, 1'b0, '{POS, POS, POS, NEG, NEG, NEG}},
			'{CFG_EXTREME, 1'b0, 1'b0, '{ONES, ONES, ONES, ONES, ONES, ONES}},
			'{CFG_EXTREME, 1'b0, 1'b0, '{NEG, NEG, NEG, NEG, NEG, NEG}},
			'{CFG_EXTREME, 1'b0, 1'b0, '{POS, POS, POS, POS, POS, POS}},
			'{CFG_EXTREME, 1'b0, 1'b0, '{32'd1, ONES, NEG, POS, 0, 32'd16}}
		};
		for (int p = 0; p < NUM_PLANES; p++)
			plane_mirror[p] = '0;
		for (int k = 0; k < 3; k++)
			cam_mirror[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; registers change only with the pipeline empty.
		cur_cfg = CFG_RESET;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg != cur_cfg) begin
				drain_results();
				build_directed_bank(dir_rows[i].cfg);
				load_bank();
				cur_cfg = dir_rows[i].cfg;
			end
			send_corners(dir_rows[i].box, dir_rows[i].typed, dir_rows[i].vis);
		end

		// Random phases, each under fresh plane and camera settings.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			drain_results();
			build_random_bank(bank_style_e'(phase % 3));
			load_bank();
			source_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_corners(random_corners(), 1'b0, 1'b0);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/abfc_pkg.sv
rtl/core/abfc_cfg.sv
rtl/core/abfc_cell.sv
rtl/core/aabb_frustum_cull_top.sv
tb/tb.sv
